// ----- rtl/fbst_pkg.sv -----
// Package: beat types, operation codes and defaults for the byte FIFO.
package fbst_pkg;

  // Default storage depth in bytes
  localparam int DEPTH_DEF = 128;

  // Reset value of the capacity register
  localparam logic [7:0] CAP_RESET = 8'd128;

  // Operation codes carried in the mode field
  localparam logic [2:0] MODE_PUT    = 3'd0;
  localparam logic [2:0] MODE_GET    = 3'd1;
  localparam logic [2:0] MODE_PEEK   = 3'd2;
  localparam logic [2:0] MODE_DROP   = 3'd3;
  localparam logic [2:0] MODE_SCAN   = 3'd4;
  localparam logic [2:0] MODE_TOKEN  = 3'd5;
  localparam logic [2:0] MODE_STATUS = 3'd6;

  // Input beat
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic [5:0] max_len;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       ok;
    logic [7:0] fill_count;
    logic       is_full;
    logic       is_empty;
    logic       last;
    logic [5:0] token_len;
  } out_item_t;

endpackage

// ----- rtl/byte_fifo_with_scan_and_token.sv -----
// Top level: byte FIFO with scan and token read, storage plus sequencer.
//
//  channel  ports                       payload
//  -------  --------------------------  -----------------------------
//  input    in_valid / in_ready         in_data  (in_item_t)
//  result   out_valid / out_ready       out_data (out_item_t)
//  config   cfg_valid / cfg_ready       cfg_data (capacity, 8 bits)
//
// One item at a time. Put, drop, status, get and peek: accepted in idle, then
// one beat to the result register once it is free. Scan and token walk held
// bytes through the single read port, one byte a cycle; a token then emits each
// beat by a read, then a load, and ends with one closing state.
// Reset empties the FIFO and sets capacity 128; storage needs no clearing.
// A stalled result holds its beat; a new item is taken while it waits.
module byte_fifo_with_scan_and_token #(
  parameter int DEPTH = fbst_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fbst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fbst_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  import fbst_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // Sequencer and result register
  fbst_core #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Byte storage
  fbst_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ----- rtl/fbst_mem.sv -----
// Byte storage: one write port, one read port, registered read data.
module fbst_mem #(
  parameter int DEPTH = fbst_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/fbst_core.sv -----
// Control: operation sequencer, pointers, scan walk, token emit and result register.
module fbst_core #(
  parameter int DEPTH = fbst_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fbst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fbst_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [7:0]          mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  logic [7:0]          mem_rdata
);

  import fbst_pkg::*;

  localparam int VW = (CW > 8) ? CW : 8;
  localparam int WW = (CW > 6) ? CW : 6;
  localparam logic [VW-1:0] DEPTH_V = VW'(DEPTH);
  localparam logic [CW-1:0] CAP_RST =
    (VW'(CAP_RESET) > DEPTH_V) ? CW'(DEPTH) : CW'(CAP_RESET);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ONE  = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_DEC  = 7'b0001000,
    S_TRD  = 7'b0010000,
    S_TOUT = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [2:0]    mode_r, mode_nxt;
  logic [7:0]    db_r, db_nxt;
  logic [5:0]    maxlen_r, maxlen_nxt;
  logic [CW-1:0] cap_r, cap_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic [CW-1:0] cmp_r, cmp_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          pend_r, pend_nxt;
  logic          stop_r, stop_nxt;
  logic          found_r, found_nxt;
  logic [5:0]    e_r, e_nxt;
  logic          extra_r, extra_nxt;
  logic [CW-1:0] fin_r, fin_nxt;
  logic [5:0]    ecnt_r, ecnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic          slot_free;
  logic          in_acc;
  logic [CW-1:0] one_cnt;
  logic [VW-1:0] cfg_v;
  logic [WW-1:0] kx, mx;

  // Ring increment that wraps at the effective capacity
  function automatic logic [AW-1:0] nxt_idx(input logic [AW-1:0] p, input logic [CW-1:0] c);
    logic [CW-1:0] n;
    n = CW'(p) + CW'(1);
    return (n >= c) ? '0 : n[AW-1:0];
  endfunction

  // Ring decrement for dropping the newest byte
  function automatic logic [AW-1:0] prv_idx(input logic [AW-1:0] p, input logic [CW-1:0] c);
    logic [CW-1:0] m;
    m = c - CW'(1);
    return (p == '0) ? m[AW-1:0] : p - AW'(1);
  endfunction

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_v     = VW'(cfg_data);
  assign kx        = WW'(k_r);
  assign mx        = WW'(maxlen_r);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    db_nxt        = db_r;
    maxlen_nxt    = maxlen_r;
    cap_nxt       = cap_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    held_nxt      = held_r;
    ptr_nxt       = ptr_r;
    iss_nxt       = iss_r;
    cmp_nxt       = cmp_r;
    k_nxt         = k_r;
    pend_nxt      = 1'b0;
    stop_nxt      = stop_r;
    found_nxt     = found_r;
    e_nxt         = e_r;
    extra_nxt     = extra_r;
    fin_nxt       = fin_r;
    ecnt_nxt      = ecnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    one_cnt       = held_r;
    mem_we        = 1'b0;
    mem_waddr     = wr_ptr_r;
    mem_wdata     = db_r;
    mem_re        = 1'b0;
    mem_raddr     = rd_ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          // Capacity write also empties the FIFO
          if (cfg_v == '0) begin
            cap_nxt = CW'(1);
          end else if (cfg_v > DEPTH_V) begin
            cap_nxt = CW'(DEPTH);
          end else begin
            cap_nxt = cfg_v[CW-1:0];
          end
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          held_nxt   = '0;
        end else if (in_acc) begin
          mode_nxt   = in_data.mode;
          db_nxt     = in_data.data_byte;
          maxlen_nxt = in_data.max_len;
          // Oldest byte fetched up front for get and peek
          mem_re     = (in_data.mode == MODE_GET) || (in_data.mode == MODE_PEEK);
          if ((in_data.mode == MODE_SCAN) || (in_data.mode == MODE_TOKEN)) begin
            ptr_nxt   = rd_ptr_r;
            iss_nxt   = '0;
            cmp_nxt   = '0;
            stop_nxt  = 1'b0;
            found_nxt = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_ONE;
          end
        end
      end

      S_ONE: begin
        if (slot_free) begin
          out_nxt.out_byte  = '0;
          out_nxt.ok        = 1'b0;
          out_nxt.last      = 1'b1;
          out_nxt.token_len = '0;
          state_nxt         = S_IDLE;
          case (mode_r)
            MODE_PUT: begin
              if (held_r < cap_r) begin
                mem_we     = 1'b1;
                wr_ptr_nxt = nxt_idx(wr_ptr_r, cap_r);
                one_cnt    = held_r + CW'(1);
                out_nxt.ok = 1'b1;
              end
            end
            MODE_GET: begin
              if (held_r != '0) begin
                rd_ptr_nxt       = nxt_idx(rd_ptr_r, cap_r);
                one_cnt          = held_r - CW'(1);
                out_nxt.ok       = 1'b1;
                out_nxt.out_byte = mem_rdata;
              end
            end
            MODE_PEEK: begin
              if (held_r != '0) begin
                out_nxt.ok       = 1'b1;
                out_nxt.out_byte = mem_rdata;
              end
            end
            MODE_DROP: begin
              if (held_r != '0) begin
                wr_ptr_nxt = prv_idx(wr_ptr_r, cap_r);
                one_cnt    = held_r - CW'(1);
                out_nxt.ok = 1'b1;
              end
            end
            MODE_SCAN: begin
              out_nxt.ok = found_r;
            end
            MODE_TOKEN: begin
              out_nxt.ok = found_r;
              one_cnt    = fin_r;
              state_nxt  = S_FIN;
            end
            default: begin
              out_nxt.ok = 1'b0;
            end
          endcase
          held_nxt           = (mode_r == MODE_TOKEN) ? held_r : one_cnt;
          out_nxt.fill_count = 8'(one_cnt);
          out_nxt.is_full    = (one_cnt == cap_r);
          out_nxt.is_empty   = (one_cnt == '0);
          out_valid_nxt      = 1'b1;
        end
      end

      S_SCAN: begin
        // Reads issue every cycle while unread bytes remain; each compare follows in the cycle after its read
        if (iss_r < held_r) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_r;
          ptr_nxt   = nxt_idx(ptr_r, cap_r);
          iss_nxt   = iss_r + CW'(1);
          pend_nxt  = 1'b1;
        end
        if (pend_r) begin
          cmp_nxt = cmp_r + CW'(1);
          if (!stop_r && ((mem_rdata == 8'd0) || (mem_rdata == db_r))) begin
            stop_nxt = 1'b1;
            k_nxt    = cmp_r;
          end
          if (mem_rdata == db_r) begin
            found_nxt = 1'b1;
            pend_nxt  = 1'b0;
            state_nxt = S_DEC;
          end
        end else if (iss_r == held_r) begin
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        // Token length, stop-byte pop and final count
        if (!found_r) begin
          e_nxt     = '0;
          extra_nxt = 1'b0;
        end else if (kx < mx) begin
          e_nxt     = kx[5:0];
          extra_nxt = 1'b1;
        end else begin
          e_nxt     = maxlen_r;
          extra_nxt = 1'b0;
        end
        if ((mode_r == MODE_TOKEN) && found_r) begin
          fin_nxt = held_r - CW'(e_nxt) - CW'(extra_nxt);
        end else begin
          fin_nxt = held_r;
        end
        ecnt_nxt = '0;
        if ((mode_r == MODE_TOKEN) && (e_nxt != '0)) begin
          state_nxt = S_TRD;
        end else begin
          state_nxt = S_ONE;
        end
      end

      S_TRD: begin
        mem_re    = 1'b1;
        mem_raddr = rd_ptr_r;
        state_nxt = S_TOUT;
      end

      S_TOUT: begin
        if (slot_free) begin
          out_nxt.out_byte   = mem_rdata;
          out_nxt.ok         = 1'b1;
          out_nxt.fill_count = 8'(fin_r);
          out_nxt.is_full    = (fin_r == cap_r);
          out_nxt.is_empty   = (fin_r == '0);
          out_nxt.last       = (ecnt_r + 6'd1 == e_r);
          out_nxt.token_len  = (ecnt_r + 6'd1 == e_r) ? e_r : '0;
          out_valid_nxt      = 1'b1;
          rd_ptr_nxt         = nxt_idx(rd_ptr_r, cap_r);
          ecnt_nxt           = ecnt_r + 6'd1;
          state_nxt          = (ecnt_r + 6'd1 == e_r) ? S_FIN : S_TRD;
        end
      end

      S_FIN: begin
        if (extra_r) begin
          rd_ptr_nxt = nxt_idx(rd_ptr_r, cap_r);
        end
        held_nxt  = fin_r;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RST;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      held_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      held_r      <= held_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and walk payload
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    db_r     <= db_nxt;
    maxlen_r <= maxlen_nxt;
    ptr_r    <= ptr_nxt;
    iss_r    <= iss_nxt;
    cmp_r    <= cmp_nxt;
    k_r      <= k_nxt;
    stop_r   <= stop_nxt;
    found_r  <= found_nxt;
    e_r      <= e_nxt;
    extra_r  <= extra_nxt;
    fin_r    <= fin_nxt;
    ecnt_r   <= ecnt_nxt;
    out_r    <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  a_held_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= cap_r) else $error("fill count above capacity");
  a_ptrs_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_ptr_r < cap_r) && (wr_ptr_r < cap_r)) else $error("pointer outside ring");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken while busy");
  a_len_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last |-> out_r.token_len == '0) else $error("token_len off last beat");
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TOUT) |-> (ecnt_r < e_r)) else $error("token emit past its length");
`endif

endmodule

// ----- verif/byte_fifo_with_scan_and_token_test.sv -----
// Testbench for the byte FIFO with scan and token read: predictor, driver and beat checker.
`timescale 1ns / 1ps

module byte_fifo_with_scan_and_token_test;
  import fbst_pkg::*;

  localparam int         STORE_DEPTH  = DEPTH_DEF;
  localparam logic [2:0] MODE_SPARE   = 3'd7;
  localparam int         CYCLE_LIMIT  = 16_000_000;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         PHASE_ITEMS  = 32;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  byte_fifo_with_scan_and_token dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the FIFO state
  logic [7:0] fifo_mem [STORE_DEPTH];
  int         rd_ptr  = 0;
  int         wr_ptr  = 0;
  int         held    = 0;
  logic [7:0] cap_reg = CAP_RESET;

  // Result beats still owed by the block, oldest first
  out_item_t  beats_due [$];
  out_item_t  want;

  // Run bookkeeping
  int fails         = 0;
  int cycles        = 0;
  int items_sent    = 0;
  int beats_checked = 0;
  int cfg_writes    = 0;
  int token_reads   = 0;

  // Idle control for both sides
  bit tx_gaps   = 1'b0;
  bit rx_gaps   = 1'b0;
  int rx_pause  = 0;
  int hold_left = 0;

  function automatic int cap_eff();
    if (cap_reg == 8'd0) return 1;
    if (cap_reg > STORE_DEPTH) return STORE_DEPTH;
    return int'(cap_reg);
  endfunction

  // Pointers wrap at the effective capacity
  function automatic int ptr_next(int i);
    return (i + 1 >= cap_eff()) ? 0 : i + 1;
  endfunction

  function automatic logic [7:0] pop_oldest();
    logic [7:0] v;
    if (held == 0) return 8'd0;
    v = fifo_mem[rd_ptr];
    rd_ptr = ptr_next(rd_ptr);
    held--;
    return v;
  endfunction

  function automatic bit holds_byte(logic [7:0] c);
    int p;
    int i;
    p = rd_ptr;
    for (i = 0; i < held; i++) begin
      if (fifo_mem[p] == c) return 1'b1;
      p = ptr_next(p);
    end
    return 1'b0;
  endfunction

  // A capacity write also empties the FIFO
  function automatic void load_capacity(logic [7:0] v);
    cap_reg = v;
    rd_ptr  = 0;
    wr_ptr  = 0;
    held    = 0;
  endfunction

  // Work out the beats one input item produces and queue them
  function automatic void predict_item(in_item_t it);
    out_item_t  res [$];
    out_item_t  b;
    logic [7:0] c;
    int         n;
    int         k;
    b      = '0;
    b.last = 1'b1;
    n      = 0;
    case (it.mode)
      MODE_PUT: begin
        if (held < cap_eff()) begin
          fifo_mem[wr_ptr] = it.data_byte;
          wr_ptr = ptr_next(wr_ptr);
          held++;
          b.ok = 1'b1;
        end
      end
      MODE_GET: begin
        b.ok       = (held != 0);
        b.out_byte = pop_oldest();
      end
      MODE_PEEK: begin
        if (held != 0) begin
          b.ok       = 1'b1;
          b.out_byte = fifo_mem[rd_ptr];
        end
      end
      MODE_DROP: begin
        if (held != 0) begin
          wr_ptr = (wr_ptr == 0) ? cap_eff() - 1 : wr_ptr - 1;
          held--;
          b.ok = 1'b1;
        end
      end
      MODE_SCAN: begin
        b.ok = holds_byte(it.data_byte);
      end
      MODE_TOKEN: begin
        token_reads++;
        if (holds_byte(it.data_byte)) begin
          b.ok = 1'b1;
          // Pop until terminator, zero byte or length limit
          while (n < int'(it.max_len)) begin
            c = pop_oldest();
            if (c == 8'd0 || c == it.data_byte) break;
            b.out_byte = c;
            b.last     = 1'b0;
            res.push_back(b);
            n++;
          end
          if (n > 0) begin
            b = res.pop_back();
            b.last      = 1'b1;
            b.token_len = 6'(n);
            res.push_back(b);
          end
        end
      end
      default: begin
        // status and the spare code report fill state only
      end
    endcase
    if (res.size() == 0) res.push_back(b);
    // Fill state is the one after the whole item
    for (k = 0; k < res.size(); k++) begin
      b = res[k];
      b.fill_count = 8'(held);
      b.is_full    = (held == cap_eff());
      b.is_empty   = (held == 0);
      beats_due.push_back(b);
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      fails++;
    end
  endfunction

  // Mostly short idle gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(15, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic in_item_t make_item(logic [2:0] m, logic [7:0] d, logic [5:0] l);
    in_item_t it;
    it.mode      = m;
    it.data_byte = d;
    it.max_len   = l;
    return it;
  endfunction

  // Bytes from a small alphabet so terminators are often held
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r <= 2) return 8'($urandom_range(0, 255));
    return 8'(8'h41 + $urandom_range(0, 5));
  endfunction

  function automatic in_item_t random_item();
    int         r;
    logic [2:0] m;
    logic [5:0] l;
    r = $urandom_range(0, 99);
    if (r < 40)      m = MODE_PUT;
    else if (r < 50) m = MODE_GET;
    else if (r < 55) m = MODE_PEEK;
    else if (r < 60) m = MODE_DROP;
    else if (r < 70) m = MODE_SCAN;
    else if (r < 90) m = MODE_TOKEN;
    else if (r < 97) m = MODE_STATUS;
    else             m = MODE_SPARE;
    if (m == MODE_TOKEN && $urandom_range(0, 3) != 0) l = 6'($urandom_range(0, 6));
    else l = 6'($urandom_range(0, 63));
    return make_item(m, pick_byte(), l);
  endfunction

  // Offer one input beat and predict once it is taken
  task automatic send_item(in_item_t it);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
    items_sent++;
  endtask

  // Stop offering and let every owed beat arrive
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(logic [7:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    load_capacity(v);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Status, spare, get, peek, drop and token on an empty FIFO
  task automatic test_empty_fifo();
    send_item(make_item(MODE_STATUS, 8'h00, 6'd0));
    send_item(make_item(MODE_SPARE,  8'hFF, 6'd63));
    send_item(make_item(MODE_GET,    8'h00, 6'd0));
    send_item(make_item(MODE_PEEK,   8'h00, 6'd0));
    send_item(make_item(MODE_DROP,   8'h00, 6'd0));
    send_item(make_item(MODE_TOKEN,  8'h2C, 6'd63));
  endtask

  // Put, peek, scan, the token stop conditions, drop and get
  task automatic test_basic_ops();
    send_item(make_item(MODE_PUT,   8'h41, 6'd0));
    send_item(make_item(MODE_PUT,   8'h00, 6'd0));
    send_item(make_item(MODE_PUT,   8'h42, 6'd0));
    send_item(make_item(MODE_PUT,   8'h2C, 6'd0));
    send_item(make_item(MODE_PUT,   8'h43, 6'd0));
    send_item(make_item(MODE_PEEK,  8'h00, 6'd0));
    send_item(make_item(MODE_SCAN,  8'h42, 6'd0));
    send_item(make_item(MODE_SCAN,  8'h99, 6'd0));
    // zero byte ends the token
    send_item(make_item(MODE_TOKEN, 8'h2C, 6'd63));
    // no length allowed: taken, nothing emitted
    send_item(make_item(MODE_TOKEN, 8'h2C, 6'd0));
    // length limit leaves the terminator held
    send_item(make_item(MODE_TOKEN, 8'h2C, 6'd1));
    // terminator first: consumed, nothing emitted
    send_item(make_item(MODE_TOKEN, 8'h2C, 6'd5));
    send_item(make_item(MODE_DROP,  8'h00, 6'd0));
    send_item(make_item(MODE_PUT,   8'hFF, 6'd0));
    send_item(make_item(MODE_GET,   8'h00, 6'd0));
  endtask

  // Capacity of one, and zero acting as one
  task automatic test_tiny_capacity();
    write_capacity(8'd1);
    send_item(make_item(MODE_PUT,    8'h5A, 6'd0));
    send_item(make_item(MODE_PUT,    8'h01, 6'd0));
    send_item(make_item(MODE_STATUS, 8'h00, 6'd0));
    send_item(make_item(MODE_GET,    8'h00, 6'd0));
    write_capacity(8'd0);
    send_item(make_item(MODE_PUT,    8'hA5, 6'd0));
    send_item(make_item(MODE_PUT,    8'h00, 6'd0));
  endtask

  // Long output stall while the FIFO is filled past full
  task automatic test_backpressure();
    int i;
    write_capacity(8'd255);
    tx_gaps   = 1'b0;
    rx_gaps   = 1'b0;
    hold_left = HOLD_CYCLES;
    for (i = 0; i < STORE_DEPTH + 4; i++)
      send_item(make_item(MODE_PUT, pick_byte(), 6'($urandom_range(0, 63))));
    send_item(make_item(MODE_SCAN,  8'($urandom_range(0, 255)), 6'd0));
    send_item(make_item(MODE_TOKEN, 8'h41, 6'd63));
    send_item(make_item(MODE_TOKEN, 8'h00, 6'd63));
    send_item(make_item(MODE_GET,   8'h00, 6'd0));
  endtask

  // Random operations across a range of capacities
  task automatic test_random_mix();
    logic [7:0] caps [8];
    int         p;
    int         i;
    caps = '{8'd2, 8'd3, 8'd128, 8'd5, 8'd1, 8'd16, 8'd200, 8'd0};
    caps[7] = 8'($urandom_range(1, 255));
    for (p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      tx_gaps = (p % 3) != 2;
      rx_gaps = (p % 4) != 1;
      for (i = 0; i < PHASE_ITEMS; i++) send_item(random_item());
    end
  endtask

  // Result side readiness
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!rx_gaps) begin
        out_ready <= 1'b1;
      end else if (rx_pause > 0) begin
        out_ready <= 1'b0;
        rx_pause--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) rx_pause = pick_gap();
      end
    end
  end

  // Compare each result beat with the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (beats_due.size() == 0) begin
        $error("result beat with none owed: %p", out_data);
        fails++;
      end else begin
        want = beats_due.pop_front();
        check_field("out_byte",   want.out_byte,   out_data.out_byte);
        check_field("ok",         want.ok,         out_data.ok);
        check_field("fill_count", want.fill_count, out_data.fill_count);
        check_field("is_full",    want.is_full,    out_data.is_full);
        check_field("is_empty",   want.is_empty,   out_data.is_empty);
        check_field("last",       want.last,       out_data.last);
        check_field("token_len",  want.token_len,  out_data.token_len);
      end
      beats_checked++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Test sequence
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = 8'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_fifo();
    test_basic_ops();
    test_tiny_capacity();
    test_backpressure();
    test_random_mix();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (beats_due.size() != 0) begin
      $error("%0d result beats never arrived", beats_due.size());
      fails++;
    end

    $display("Sent %0d items, checked %0d result beats over %0d capacity writes.",
             items_sent, beats_checked, cfg_writes);
    $display("Ran %0d token reads, filled the FIFO under a long output stall.", token_reads);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
